### design/bmch_pkg.sv
// shared types and constants for the bounded max-count heap
// no dependencies; imported by the heap core, the checker and the testbench

package bmch_pkg;

    localparam int DEFAULT_CAPACITY = 1024;
    localparam int KEY_W            = 64;
    localparam int COUNT_W          = 32;
    localparam int LEFT_W           = 10;
    localparam int ENTRY_W          = KEY_W + COUNT_W;

    // operation codes carried on the kind field
    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_POP = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

### design/bmch_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module bmch_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/bounded_max_count_heap_core.sv
// top level of the bounded max-count heap: control sequencer around one entry ram
// depends on bmch_pkg and bmch_ram

// Usage
//   input channel (s_*): one word is one operation. s_kind = add (key, count) or
//   pop the entry with the largest count. s_ready is high only while the core is
//   idle, so one operation is worked at a time.
//   result channel (m_*): a pop gives one word (found, key, count, entries left);
//   an add gives none. A pop on an empty heap gives found = 0 with zero fields.
// Steps
//   add: the new entry climbs level by level. Each level is one ram read of the
//   parent followed by the compare and one write; the entry itself is written
//   where it stops, at the root or below a parent, before s_ready returns.
//   pop: the root and then the last entry are read back; each level of the
//   sift-down then reads the left child, reads the right child if there is one,
//   and compares and writes, and a final write finishes. The result word is
//   loaded into the output register when the root comes back and the register
//   is free.
// Reset: occupancy goes to zero; ram contents are not cleared, since no slot is
//   read before it is written.
// Stall: the result sits in an output register; the core keeps working an add
//   while it waits, and a later pop holds before loading until the word is taken.

module bounded_max_count_heap_core #(
    parameter int CAPACITY = bmch_pkg::DEFAULT_CAPACITY
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // operation words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [bmch_pkg::KEY_W-1:0]   s_key_in,
    input  logic [bmch_pkg::COUNT_W-1:0] s_count_in,
    // pop result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [bmch_pkg::KEY_W-1:0]   m_key_out,
    output logic [bmch_pkg::COUNT_W-1:0] m_count_out,
    output logic [bmch_pkg::LEFT_W-1:0]  m_entries_left
);

    import bmch_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] OCC_MAX = AW'(CAPACITY - 1);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_UP_RD     = 9'b000000010,   // issue parent read or finish at root
        ST_UP_CMP    = 9'b000000100,   // compare against parent, move parent down
        ST_POP_EMPTY = 9'b000001000,   // report not-found
        ST_POP_ROOT  = 9'b000010000,   // root data back, load result, read last
        ST_POP_LAST  = 9'b000100000,   // last entry back, becomes moving entry
        ST_DN_RD     = 9'b001000000,   // issue left child read or finish
        ST_DN_L      = 9'b010000000,   // left back, maybe read right
        ST_DN_R      = 9'b100000000    // right back, pick larger child
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] occ_reg, occ_next;     // entries held
    logic [AW-1:0] pos_reg, pos_next;     // slot of the hole being moved
    entry_t        ent_reg, ent_next;     // entry being sifted
    entry_t        left_reg, left_next;   // left child during sift-down

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    logic [KEY_W-1:0]     m_key_reg, m_key_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;
    logic [LEFT_W-1:0]    m_left_reg, m_left_next;

    // ram port
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    entry_t           ram_wdata, rd_entry;
    logic [ENTRY_W-1:0] ram_rdata;

    // index arithmetic
    logic [AW-1:0] pos_m1, up_idx, last_idx;
    logic [AW:0]   lc_ext, rc_ext;
    logic [31:0]   left_ext;
    logic          out_free;

    // sift-down decision
    logic          dn_decide;
    entry_t        pick_entry;
    logic [AW-1:0] pick_idx;

    assign rd_entry = entry_t'(ram_rdata);
    assign out_free = !m_valid_reg || m_ready;

    assign pos_m1   = pos_reg - 1'b1;
    assign up_idx   = pos_m1 >> 1;
    assign last_idx = occ_reg - 1'b1;
    assign lc_ext   = {pos_reg, 1'b1};
    assign rc_ext   = lc_ext + 1'b1;
    assign left_ext = 32'(last_idx);

    always_comb begin
        // right child wins a tie
        if (state_reg == ST_DN_R && left_reg.count > rd_entry.count) begin
            pick_entry = left_reg;
            pick_idx   = lc_ext[AW-1:0];
        end else if (state_reg == ST_DN_R) begin
            pick_entry = rd_entry;
            pick_idx   = rc_ext[AW-1:0];
        end else begin
            pick_entry = rd_entry;
            pick_idx   = lc_ext[AW-1:0];
        end
    end

    assign dn_decide = (state_reg == ST_DN_R) ||
                       (state_reg == ST_DN_L && rc_ext >= {1'b0, occ_reg});

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        pos_next     = pos_reg;
        ent_next     = ent_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_found_next = m_found_reg;
        m_key_next   = m_key_reg;
        m_count_next = m_count_reg;
        m_left_next  = m_left_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = ent_reg;
        ram_re       = 1'b0;
        ram_raddr    = up_idx;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_ADD) begin
                        // new entry starts in the slot after the last; at full
                        // occupancy that is the spare slot, dropped afterwards
                        ent_next.key   = s_key_in;
                        ent_next.count = s_count_in;
                        pos_next       = occ_reg;
                        if (occ_reg != OCC_MAX) begin
                            occ_next = occ_reg + 1'b1;
                        end
                        state_next = ST_UP_RD;
                    end else if (occ_reg == '0) begin
                        state_next = ST_POP_EMPTY;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = ST_POP_ROOT;
                    end
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = up_idx;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                ram_we = 1'b1;
                if (ent_reg.count > rd_entry.count) begin
                    // parent moves down into the hole
                    ram_wdata  = rd_entry;
                    pos_next   = up_idx;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_EMPTY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b0;
                    m_key_next   = '0;
                    m_count_next = '0;
                    m_left_next  = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_POP_ROOT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b1;
                    m_key_next   = rd_entry.key;
                    m_count_next = rd_entry.count;
                    m_left_next  = left_ext[LEFT_W-1:0];
                    ram_re       = 1'b1;
                    ram_raddr    = last_idx;
                    occ_next     = last_idx;
                    state_next   = ST_POP_LAST;
                end
            end
            ST_POP_LAST: begin
                ent_next   = rd_entry;
                pos_next   = '0;
                state_next = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (lc_ext >= {1'b0, occ_reg}) begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = lc_ext[AW-1:0];
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L: begin
                left_next = rd_entry;
                if (!dn_decide) begin
                    ram_re     = 1'b1;
                    ram_raddr  = rc_ext[AW-1:0];
                    state_next = ST_DN_R;
                end
            end
            ST_DN_R: begin
                // decision handled below
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (dn_decide) begin
            ram_we = 1'b1;
            if (pick_entry.count > ent_reg.count) begin
                // larger child moves up into the hole
                ram_wdata  = pick_entry;
                pos_next   = pick_idx;
                state_next = ST_DN_RD;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        ent_reg     <= ent_next;
        left_reg    <= left_next;
        m_found_reg <= m_found_next;
        m_key_reg   <= m_key_next;
        m_count_reg <= m_count_next;
        m_left_reg  <= m_left_next;
    end

    bmch_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_key_out      = m_key_reg;
    assign m_count_out    = m_count_reg;
    assign m_entries_left = m_left_reg;

    // occupancy never passes the spare slot
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_MAX)
        else $error("occupancy above capacity - 1");

    // the sequencer never reads and writes the ram in one cycle
    a_ram_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("ram read and write in the same cycle");

    // loading a pop result removes exactly one entry
    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_ROOT && out_free) |=> occ_reg == $past(occ_reg) - 1'b1)
        else $error("pop did not decrement occupancy");

    // the hole stays within the held entries while sifting down
    a_hole_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DN_RD) |-> (pos_reg < occ_reg || pos_reg == '0))
        else $error("sift-down hole outside held entries");

    // a not-found word carries zero fields
    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_key_out == '0 && m_count_out == '0 &&
                                   m_entries_left == '0))
        else $error("not-found word with nonzero fields");

endmodule

### tb/sv/bounded_max_count_heap_checker.sv
// checker for the bounded max-count heap: watches both channels, keeps its own heap
// model, and compares every pop word against the oldest predicted one
// depends on bmch_pkg

module bounded_max_count_heap_checker #(
    parameter int CAPACITY = bmch_pkg::DEFAULT_CAPACITY
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_kind,
    input  logic [bmch_pkg::KEY_W-1:0]   s_key_in,
    input  logic [bmch_pkg::COUNT_W-1:0] s_count_in,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         m_found,
    input  logic [bmch_pkg::KEY_W-1:0]   m_key_out,
    input  logic [bmch_pkg::COUNT_W-1:0] m_count_out,
    input  logic [bmch_pkg::LEFT_W-1:0]  m_entries_left,
    output int                           mismatches,
    output int                           words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import bmch_pkg::*;

    typedef struct packed {
        logic               found;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [LEFT_W-1:0]  left;
    } pop_word_t;

    entry_t      heap_mem [CAPACITY];
    int unsigned held = 0;
    pop_word_t   pops_due [$];
    int          errs = 0;

    function automatic void swap_entries(input int a, input int b);
        entry_t t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    // new entry goes after the last one and climbs while strictly larger;
    // at full occupancy the spare slot takes it and whatever ends there is lost
    function automatic void heap_add(input logic [KEY_W-1:0] key,
                                     input logic [COUNT_W-1:0] count);
        int pos;
        int up;
        pos = held;
        if (pos > CAPACITY - 1) pos = CAPACITY - 1;
        heap_mem[pos].key   = key;
        heap_mem[pos].count = count;
        while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_mem[pos].count > heap_mem[up].count) begin
                swap_entries(pos, up);
                pos = up;
            end else begin
                break;
            end
        end
        if (held < CAPACITY - 1) held++;
    endfunction

    // root out, last entry to the root, sink toward the larger child (right on a tie)
    function automatic pop_word_t heap_pop();
        pop_word_t w;
        int        pos;
        int        lc;
        int        rc;
        int        pick;
        w = '0;
        if (held == 0) return w;
        w.found = 1'b1;
        w.key   = heap_mem[0].key;
        w.count = heap_mem[0].count;
        held--;
        heap_mem[0] = heap_mem[held];
        pos = 0;
        while (1) begin
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc >= held) break;
            if (rc >= held) pick = lc;
            else pick = (heap_mem[lc].count > heap_mem[rc].count) ? lc : rc;
            if (heap_mem[pick].count > heap_mem[pos].count) begin
                swap_entries(pos, pick);
                pos = pick;
            end else begin
                break;
            end
        end
        w.left = LEFT_W'(held);
        return w;
    endfunction

    always @(posedge aclk) begin
        pop_word_t want;
        pop_word_t got;
        if (!aresetn) begin
            held = 0;
            pops_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_found, m_key_out, m_count_out, m_entries_left};
                if (pops_due.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected word: found=%0d key=%h count=%0d left=%0d",
                                 got.found, got.key, got.count, got.left);
                end else begin
                    want = pops_due.pop_front();
                    if (got.found !== want.found || got.key !== want.key ||
                        got.count !== want.count || got.left !== want.left) begin
                        errs++;
                        if (errs <= 10)
                            $display("mismatch: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                                     want.found, want.key, want.count, want.left,
                                     got.found, got.key, got.count, got.left);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_kind == KIND_ADD) heap_add(s_key_in, s_count_in);
                else pops_due.push_back(heap_pop());
            end
        end
        mismatches <= errs;
        words_due  <= pops_due.size();
    end

endmodule

### tb/sv/bounded_max_count_heap_core_tb.sv
// top of the bounded max-count heap testbench: clock, reset, stimulus and verdict
// depends on bmch_pkg, bounded_max_count_heap_core and bounded_max_count_heap_checker

module bounded_max_count_heap_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmch_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int HOLD_CYCLES  = 400;       // long result back-pressure stretch
    localparam int DRAIN_CYCLES = 64;        // beyond the longest pop
    localparam int LIMIT_NS     = 2_000_000; // watchdog limit, in ns

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 s_valid    = 1'b0;
    logic                 s_kind     = KIND_ADD;
    logic [KEY_W-1:0]     s_key_in   = '0;
    logic [COUNT_W-1:0]   s_count_in = '0;
    logic                 m_ready    = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_found;
    logic [KEY_W-1:0]     m_key_out;
    logic [COUNT_W-1:0]   m_count_out;
    logic [LEFT_W-1:0]    m_entries_left;

    int mismatches;
    int words_due;

    // idling knobs, percent of cycles
    int gap_pct   = 0;
    int stall_pct = 0;
    // bumped by the stimulus to ask the result side for one long hold-off
    int hold_asks = 0;
    // running estimate of entries held, only used to steer the stimulus
    int fill_est  = 0;

    always #1 aclk = ~aclk;

    bounded_max_count_heap_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key_in      (s_key_in),
        .s_count_in    (s_count_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_key_out     (m_key_out),
        .m_count_out   (m_count_out),
        .m_entries_left(m_entries_left)
    );

    bounded_max_count_heap_checker #(
        .CAPACITY(CAPACITY)
    ) chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key_in      (s_key_in),
        .s_count_in    (s_count_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_key_out     (m_key_out),
        .m_count_out   (m_count_out),
        .m_entries_left(m_entries_left),
        .mismatches    (mismatches),
        .words_due     (words_due)
    );

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one word, return at the edge that accepts it
    // random gaps first; valid stays up with a fixed payload until taken
    task automatic send_op(input logic kind, input logic [KEY_W-1:0] key,
                           input logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_key_in   <= key;
        s_count_in <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (kind == KIND_ADD) begin
            if (fill_est < CAPACITY - 1) fill_est++;
        end else if (fill_est > 0) begin
            fill_est--;
        end
    endtask

    // keys: mostly full random, now and then all zeros or all ones
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // counts: extremes, a narrow band so ties are common, otherwise full range
    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return COUNT_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_rand(input int add_pct);
        logic kind;
        kind = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_POP;
        send_op(kind, rand_key(), rand_count());
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // -- directed part, no idling --
        // pop with nothing held
        send_op(KIND_POP, '0, '0);
        // field extremes and equal counts on the climb
        send_op(KIND_ADD, '0, '0);
        send_op(KIND_ADD, '1, '1);
        send_op(KIND_ADD, 64'hAAAA_AAAA_AAAA_AAAA, '1);
        send_op(KIND_ADD, 64'h5555_5555_5555_5555, '0);
        send_op(KIND_ADD, 64'h0123_4567_89AB_CDEF, 32'd5);
        send_op(KIND_ADD, 64'hFEDC_BA98_7654_3210, 32'd5);
        // empty it, one pop past empty
        repeat (7) send_op(KIND_POP, '1, '1);
        // two equal children under the root: the right one must come up
        send_op(KIND_ADD, 64'h1, 32'd9);
        send_op(KIND_ADD, 64'h2, 32'd4);
        send_op(KIND_ADD, 64'h3, 32'd4);
        send_op(KIND_ADD, 64'h4, 32'd1);
        repeat (5) send_op(KIND_POP, '0, '0);

        // -- random mixes under each idling pattern --
        repeat (100) send_rand(55);

        gap_pct <= 52;
        repeat (100) send_rand(55);

        gap_pct   <= 0;
        stall_pct <= 52;
        repeat (100) send_rand(50);

        // -- long result hold-off while pops keep coming, so the core backs up --
        stall_pct <= 0;
        hold_asks <= hold_asks + 1;
        repeat (40) send_rand(30);

        // -- fill to capacity, push past it, then work the full heap --
        gap_pct   <= 7;
        stall_pct <= 7;
        while (fill_est < CAPACITY - 1) send_rand(95);
        repeat (40) send_op(KIND_ADD, rand_key(), rand_count());
        repeat (100) send_rand(40);

        s_valid <= 1'b0;

        // let the checker count the last accepted word, wait for the last pop
        // word, then let any trailing work settle
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && words_due == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
